### rtl/core/firewall_range_rule_table_core_macros.svh
`ifndef FIREWALL_RANGE_RULE_TABLE_CORE_MACROS_SVH
`define FIREWALL_RANGE_RULE_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define FRRT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FRRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/frrt_pkg.sv
package frrt_pkg;

   localparam int DEF_RULE_SLOTS = 64;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_DEL   = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;

   localparam logic [3:0] ST_ADDED       = 4'd0;
   localparam logic [3:0] ST_ADD_INVALID = 4'd1;
   localparam logic [3:0] ST_DELETED     = 4'd2;
   localparam logic [3:0] ST_NO_MATCH    = 4'd3;
   localparam logic [3:0] ST_DEL_INVALID = 4'd4;
   localparam logic [3:0] ST_ACCEPT      = 4'd5;
   localparam logic [3:0] ST_REJECT      = 4'd6;
   localparam logic [3:0] ST_ILLEGAL     = 4'd7;
   localparam logic [3:0] ST_FULL        = 4'd8;

   // first field in the highest bits
   typedef struct packed {
      logic        port_is_range;
      logic        ip_is_range;
      logic [15:0] port_high;
      logic [15:0] port_low;
      logic [31:0] ip_high;
      logic [31:0] ip_low;
      logic [1:0]  op;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic        ip_ranged;
      logic        port_ranged;
      logic [31:0] ip_low;
      logic [31:0] ip_high;
      logic [15:0] port_low;
      logic [15:0] port_high;
   } entry_type;

   localparam int ITEM_W  = $bits(item_type);
   localparam int REQ_W   = ((ITEM_W + 7) / 8) * 8;
   localparam int COUNT_W = 7;
   localparam int RSP_W   = 16;
   localparam int RSP_PAD = RSP_W - COUNT_W - 4;

   typedef struct packed {
      logic load_item;
      logic clr_step;
      logic scan_step;
      logic note_early;
      logic commit_hit;
      logic note_miss;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic early;
      logic hit;
      logic scan_end;
   } stat_type;

endpackage

### rtl/core/frrt_ctrl.sv
`include "firewall_range_rule_table_core_macros.svh"

module frrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output frrt_pkg::cmd_type  cmd,
   input  frrt_pkg::stat_type stat
);
   import frrt_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_REPLY = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.early) begin
               cmd.note_early = 1'b1;
               state_in       = S_REPLY;
            end else if (stat.hit) begin
               cmd.commit_hit = 1'b1;
               state_in       = S_REPLY;
            end else if (stat.scan_end) begin
               cmd.note_miss = 1'b1;
               state_in      = S_REPLY;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `FRRT_ASSERT_NEXT(a_accept_scans, clock, reset, req_tvalid && req_tready, state_ff == S_SCAN, "accepted item did not start a scan")
   `FRRT_ASSERT_NOW(a_load_free, clock, reset, cmd.rsp_load, !rsp_valid_ff || rsp_tready, "result overwrote a pending item")
   `FRRT_ASSERT_NOW(a_clear_first, clock, reset, $fell(reset), state_ff == S_CLEAR, "no clearing pass after reset")

endmodule

### rtl/core/frrt_dp.sv
`include "firewall_range_rule_table_core_macros.svh"

module frrt_dp #(
   parameter int RULE_SLOTS = frrt_pkg::DEF_RULE_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [frrt_pkg::REQ_W-1:0]  req_tdata,
   input  frrt_pkg::cmd_type           cmd,
   output frrt_pkg::stat_type          stat,
   output logic [frrt_pkg::RSP_W-1:0]  rsp_tdata
);
   import frrt_pkg::*;

   localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int CW = $clog2(RULE_SLOTS + 1);
   localparam logic [AW:0]   SLOTS_N   = (AW + 1)'(RULE_SLOTS);
   localparam logic [AW-1:0] LAST_IDX  = AW'(RULE_SLOTS - 1);
   localparam logic [CW-1:0] SLOTS_CNT = CW'(RULE_SLOTS);

   entry_type mem [RULE_SLOTS];

   item_type        item_ff;
   entry_type       rd_ff;
   logic [AW-1:0]   rd_idx_ff;
   logic            live_ff;
   logic            live_in;
   logic [AW:0]     iss_ff;
   logic [AW:0]     iss_in;
   logic [CW-1:0]   cnt_ff;
   logic [CW-1:0]   cnt_in;
   logic [3:0]      stat_ff;
   logic [3:0]      stat_in;
   logic [RSP_W-1:0] rsp_ff;

   logic            iss_end;
   logic            ip_bad;
   logic            port_bad;
   logic            early;
   logic [3:0]      early_code;
   logic [3:0]      hit_code;
   logic [3:0]      miss_code;
   logic            slot_hit;
   logic            del_match;
   logic            ip_cover;
   logic            port_cover;
   logic            wr_en;
   logic [AW-1:0]   wr_idx;
   entry_type       wr_data;
   logic [CW+6:0]   cnt_ext;

   assign iss_end  = (iss_ff == SLOTS_N);
   assign ip_bad   = item_ff.ip_is_range && !(item_ff.ip_low < item_ff.ip_high);
   assign port_bad = item_ff.port_is_range && !(item_ff.port_low < item_ff.port_high);

   assign ip_cover = rd_ff.ip_ranged
      ? (item_ff.ip_low >= rd_ff.ip_low && item_ff.ip_low <= rd_ff.ip_high)
      : (item_ff.ip_low == rd_ff.ip_low);
   assign port_cover = rd_ff.port_ranged
      ? (item_ff.port_low >= rd_ff.port_low && item_ff.port_low <= rd_ff.port_high)
      : (item_ff.port_low == rd_ff.port_low);

   assign del_match = rd_ff.valid
      && (rd_ff.ip_ranged == item_ff.ip_is_range)
      && (rd_ff.port_ranged == item_ff.port_is_range)
      && (rd_ff.ip_low == item_ff.ip_low)
      && (rd_ff.port_low == item_ff.port_low)
      && (!item_ff.ip_is_range || rd_ff.ip_high == item_ff.ip_high)
      && (!item_ff.port_is_range || rd_ff.port_high == item_ff.port_high);

   always_comb begin
      unique case (item_ff.op)
         OP_ADD: begin
            early      = ip_bad || port_bad;
            early_code = ST_ADD_INVALID;
            slot_hit   = !rd_ff.valid;
            hit_code   = ST_ADDED;
            miss_code  = ST_FULL;
         end
         OP_DEL: begin
            early      = ip_bad || port_bad;
            early_code = ST_DEL_INVALID;
            slot_hit   = del_match;
            hit_code   = ST_DELETED;
            miss_code  = ST_NO_MATCH;
         end
         OP_CHECK: begin
            early      = item_ff.ip_is_range || item_ff.port_is_range;
            early_code = ST_ILLEGAL;
            slot_hit   = rd_ff.valid && ip_cover && port_cover;
            hit_code   = ST_ACCEPT;
            miss_code  = ST_REJECT;
         end
         default: begin
            early      = 1'b1;
            early_code = ST_ILLEGAL;
            slot_hit   = 1'b0;
            hit_code   = ST_ILLEGAL;
            miss_code  = ST_ILLEGAL;
         end
      endcase
   end

   assign stat.sweep_done = iss_end;
   assign stat.early      = early;
   assign stat.hit        = live_ff && slot_hit;
   assign stat.scan_end   = live_ff && (rd_idx_ff == LAST_IDX);

   // scan and sweep address
   always_comb begin
      iss_in  = iss_ff;
      live_in = 1'b0;
      if (cmd.load_item) begin
         iss_in = '0;
      end else if ((cmd.clr_step || cmd.scan_step) && !iss_end) begin
         iss_in  = iss_ff + 1'b1;
         live_in = cmd.scan_step;
      end
   end

   // rule count and pending status
   always_comb begin
      cnt_in  = cnt_ff;
      stat_in = stat_ff;
      if (cmd.note_early) begin
         stat_in = early_code;
      end else if (cmd.note_miss) begin
         stat_in = miss_code;
      end else if (cmd.commit_hit) begin
         stat_in = hit_code;
         if (item_ff.op == OP_ADD) begin
            cnt_in = cnt_ff + 1'b1;
         end else if (item_ff.op == OP_DEL) begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // memory write side
   always_comb begin
      wr_en               = cmd.clr_step && !iss_end;
      wr_idx              = iss_ff[AW-1:0];
      wr_data.valid       = 1'b0;
      wr_data.ip_ranged   = item_ff.ip_is_range;
      wr_data.port_ranged = item_ff.port_is_range;
      wr_data.ip_low      = item_ff.ip_low;
      wr_data.ip_high     = item_ff.ip_high;
      wr_data.port_low    = item_ff.port_low;
      wr_data.port_high   = item_ff.port_high;
      if (cmd.commit_hit && (item_ff.op == OP_ADD || item_ff.op == OP_DEL)) begin
         wr_en         = 1'b1;
         wr_idx        = rd_idx_ff;
         wr_data.valid = (item_ff.op == OP_ADD);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && !iss_end) begin
         rd_ff     <= mem[iss_ff[AW-1:0]];
         rd_idx_ff <= iss_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= item_type'(req_tdata[ITEM_W-1:0]);
      end
      stat_ff <= stat_in;
      if (cmd.rsp_load) begin
         rsp_ff <= {{RSP_PAD{1'b0}}, cnt_ext[COUNT_W-1:0], stat_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff  <= '0;
         live_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         iss_ff  <= iss_in;
         live_ff <= live_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign cnt_ext   = {7'd0, cnt_ff};
   assign rsp_tdata = rsp_ff;

   `FRRT_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= SLOTS_CNT, "rule count above table size")
   `FRRT_ASSERT_NOW(a_add_room, clock, reset, cmd.commit_hit && item_ff.op == OP_ADD, cnt_ff < SLOTS_CNT, "add committed into a full table")
   `FRRT_ASSERT_NOW(a_del_some, clock, reset, cmd.commit_hit && item_ff.op == OP_DEL, cnt_ff != '0, "delete committed on an empty table")

endmodule

### rtl/core/firewall_range_rule_table_core.sv
// sequence: accept, then a scan over the one-port rule memory that stops at the first hit, then a
// reply once the output slot is free; an item that fails its range or op check replies without a scan
// flow: one item at a time; the next item is taken only after the last reply is loaded
// reset: synchronous; afterwards a clearing pass marks every slot free, and no item is taken
// until it ends
module firewall_range_rule_table_core #(
   parameter int RULE_SLOTS = frrt_pkg::DEF_RULE_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // op, ip_low, ip_high, port_low, port_high, ip_is_range, port_is_range
   input  logic [frrt_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status, rules_in_use
   output logic [frrt_pkg::RSP_W-1:0]  rsp_tdata
);
   import frrt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   frrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   frrt_dp #(
      .RULE_SLOTS (RULE_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### dv/firewall_range_rule_table_core_tb.sv
`timescale 1ns / 100ps

module firewall_range_rule_table_core_tb;
   import frrt_pkg::*;

   localparam int RULE_SLOTS = DEF_RULE_SLOTS;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam int RANDOM_ITEMS = 1900;
   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [31:0] ADDR_TOP = 32'hFFFF_FFFF;
   localparam logic [31:0] PORT_TOP = 32'h0000_FFFF;

   typedef struct packed {
      logic [3:0]         status;
      logic [COUNT_W-1:0] rules;
   } verdict_type;

   typedef struct {
      item_type    it;
      bit          known;
      verdict_type v;
   } row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // op, ip_low, ip_high, port_low, port_high, ip_is_range, port_is_range
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   // status, rules_in_use
   logic [RSP_W-1:0] rsp_tdata;

   entry_type rule_mem [RULE_SLOTS];
   int live_rules;
   verdict_type pending_verdicts[$];
   row_type directed_rows[$];
   int errors = 0;
   int burst_left = 0;
   int cycle_count = 0;

   firewall_range_rule_table_core #(
      .RULE_SLOTS(RULE_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic logic [3:0] apply_rule_op(input item_type it);
      logic ranges_ok;
      logic ip_hit;
      logic port_hit;
      logic done;
      logic [3:0] st;
      int i;
      ranges_ok = (!it.ip_is_range || it.ip_low < it.ip_high) &&
                  (!it.port_is_range || it.port_low < it.port_high);
      done = 1'b0;
      case (it.op)
         OP_ADD: begin
            if (!ranges_ok) begin
               st = ST_ADD_INVALID;
            end else begin
               st = ST_FULL;
               for (i = 0; i < RULE_SLOTS && !done; i++) begin
                  if (!rule_mem[i].valid) begin
                     rule_mem[i].valid = 1'b1;
                     rule_mem[i].ip_ranged = it.ip_is_range;
                     rule_mem[i].port_ranged = it.port_is_range;
                     rule_mem[i].ip_low = it.ip_low;
                     rule_mem[i].ip_high = it.ip_is_range ? it.ip_high : 32'h0;
                     rule_mem[i].port_low = it.port_low;
                     rule_mem[i].port_high = it.port_is_range ? it.port_high : 16'h0;
                     live_rules++;
                     st = ST_ADDED;
                     done = 1'b1;
                  end
               end
            end
         end
         OP_DEL: begin
            if (!ranges_ok) begin
               st = ST_DEL_INVALID;
            end else begin
               st = ST_NO_MATCH;
               for (i = 0; i < RULE_SLOTS && !done; i++) begin
                  if (rule_mem[i].valid &&
                      rule_mem[i].ip_ranged == it.ip_is_range &&
                      rule_mem[i].port_ranged == it.port_is_range &&
                      rule_mem[i].ip_low == it.ip_low &&
                      rule_mem[i].port_low == it.port_low &&
                      (!it.ip_is_range || rule_mem[i].ip_high == it.ip_high) &&
                      (!it.port_is_range || rule_mem[i].port_high == it.port_high)) begin
                     rule_mem[i].valid = 1'b0;
                     live_rules--;
                     st = ST_DELETED;
                     done = 1'b1;
                  end
               end
            end
         end
         OP_CHECK: begin
            if (it.ip_is_range || it.port_is_range) begin
               st = ST_ILLEGAL;
            end else begin
               st = ST_REJECT;
               for (i = 0; i < RULE_SLOTS && !done; i++) begin
                  if (rule_mem[i].ip_ranged)
                     ip_hit = it.ip_low >= rule_mem[i].ip_low && it.ip_low <= rule_mem[i].ip_high;
                  else
                     ip_hit = it.ip_low == rule_mem[i].ip_low;
                  if (rule_mem[i].port_ranged)
                     port_hit = it.port_low >= rule_mem[i].port_low &&
                                it.port_low <= rule_mem[i].port_high;
                  else
                     port_hit = it.port_low == rule_mem[i].port_low;
                  if (rule_mem[i].valid && ip_hit && port_hit) begin
                     st = ST_ACCEPT;
                     done = 1'b1;
                  end
               end
            end
         end
         default: st = ST_ILLEGAL;
      endcase
      return st;
   endfunction

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return ADDR_TOP;
         2: return 32'h0A00_0000 + $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_port();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return PORT_TOP;
         2: return 32'd80 + $urandom_range(0, 3);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic void make_span(input logic [31:0] top, input logic [31:0] seed,
                                     output logic [31:0] lo, output logic [31:0] hi);
      logic [31:0] t;
      lo = seed & top;
      if ($urandom_range(0, 1))
         hi = (lo + $urandom_range(1, 300)) & top;
      else
         hi = $urandom & top;
      if (hi < lo) begin
         t = lo;
         lo = hi;
         hi = t;
      end
      if (hi == lo) begin
         if (lo == top)
            lo = lo - 1;
         else
            hi = lo + 1;
      end
   endfunction

   function automatic item_type tidy_range(input item_type it);
      logic [31:0] lo;
      logic [31:0] hi;
      if (it.ip_is_range) begin
         make_span(ADDR_TOP, it.ip_low, lo, hi);
         it.ip_low = lo;
         it.ip_high = hi;
      end
      if (it.port_is_range) begin
         make_span(PORT_TOP, {16'h0, it.port_low}, lo, hi);
         it.port_low = lo[15:0];
         it.port_high = hi[15:0];
      end
      return it;
   endfunction

   // low end at or above high end
   function automatic item_type spoil_range(input item_type it);
      if ($urandom_range(0, 1)) begin
         it.ip_is_range = 1'b1;
         if ($urandom_range(0, 3) == 0)
            it.ip_high = it.ip_low;
         else if (it.ip_high > it.ip_low)
            {it.ip_low, it.ip_high} = {it.ip_high, it.ip_low};
      end else begin
         it.port_is_range = 1'b1;
         if ($urandom_range(0, 3) == 0)
            it.port_high = it.port_low;
         else if (it.port_high > it.port_low)
            {it.port_low, it.port_high} = {it.port_high, it.port_low};
      end
      return it;
   endfunction

   function automatic int pick_live();
      int i;
      if (live_rules == 0)
         return -1;
      i = $urandom_range(0, RULE_SLOTS - 1);
      while (!rule_mem[i].valid)
         i = (i + 1) % RULE_SLOTS;
      return i;
   endfunction

   // a value on, inside or just outside a rule's bounds
   function automatic logic [31:0] point_near(input logic [31:0] lo, input logic [31:0] hi,
                                              input logic ranged, input logic [31:0] top);
      logic [63:0] span;
      span = {32'h0, hi} - {32'h0, lo} + 64'd1;
      if (!ranged)
         return ($urandom_range(0, 4) == 0) ? ((lo + 1) & top) : lo;
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         2: return (lo - 1) & top;
         3: return (hi + 1) & top;
         default: return lo + 32'({$urandom, $urandom} % span);
      endcase
   endfunction

   function automatic item_type make_item(input int add_pct, input int del_pct);
      item_type it;
      int r;
      int slot;
      it.op = OP_CHECK;
      it.ip_low = pick_addr();
      it.ip_high = $urandom;
      it.port_low = 16'(pick_port());
      it.port_high = 16'($urandom_range(0, 65535));
      it.ip_is_range = 1'($urandom_range(0, 1));
      it.port_is_range = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
         it.op = OP_ADD;
         it = ($urandom_range(0, 99) < 8) ? spoil_range(it) : tidy_range(it);
      end else if (r < add_pct + del_pct) begin
         it.op = OP_DEL;
         slot = pick_live();
         r = $urandom_range(0, 99);
         if (r < 75 && slot >= 0) begin
            it.ip_low = rule_mem[slot].ip_low;
            it.port_low = rule_mem[slot].port_low;
            it.ip_is_range = rule_mem[slot].ip_ranged;
            it.port_is_range = rule_mem[slot].port_ranged;
            if (it.ip_is_range)
               it.ip_high = rule_mem[slot].ip_high;
            if (it.port_is_range)
               it.port_high = rule_mem[slot].port_high;
            if ($urandom_range(0, 9) == 0)
               it.port_low = it.port_low + 16'd1;
         end else if (r < 85) begin
            it = spoil_range(it);
         end else begin
            it = tidy_range(it);
         end
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            it.op = OP_UNKNOWN;
         end else if (r < 8) begin
            if (!it.ip_is_range && !it.port_is_range)
               it.ip_is_range = 1'b1;
         end else begin
            it.ip_is_range = 1'b0;
            it.port_is_range = 1'b0;
            slot = pick_live();
            if (r < 75 && slot >= 0) begin
               it.ip_low = point_near(rule_mem[slot].ip_low, rule_mem[slot].ip_high,
                                      rule_mem[slot].ip_ranged, ADDR_TOP);
               it.port_low = 16'(point_near({16'h0, rule_mem[slot].port_low},
                                            {16'h0, rule_mem[slot].port_high},
                                            rule_mem[slot].port_ranged, PORT_TOP));
            end
         end
      end
      return it;
   endfunction

   task automatic add_row(input logic [1:0] op, input logic [31:0] ipl, input logic [31:0] iph,
                          input logic [15:0] pl, input logic [15:0] ph, input logic ipr,
                          input logic pr, input bit known, input logic [3:0] st,
                          input int cnt);
      row_type r;
      r.it.op = op;
      r.it.ip_low = ipl;
      r.it.ip_high = iph;
      r.it.port_low = pl;
      r.it.port_high = ph;
      r.it.ip_is_range = ipr;
      r.it.port_is_range = pr;
      r.known = known;
      r.v.status = st;
      r.v.rules = COUNT_W'(cnt);
      directed_rows.push_back(r);
   endtask

   task automatic offer_item(input item_type it, input bit known, input verdict_type known_v);
      verdict_type v;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tdata <= {{(REQ_W - ITEM_W){1'b0}}, it};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      v.status = apply_rule_op(it);
      v.rules = COUNT_W'(live_rules);
      pending_verdicts.push_back(known ? known_v : v);
      burst_left--;
   endtask

   task automatic wait_replies();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      verdict_type none;
      int phase_len;
      int kind;
      int sent;
      int add_pct;
      int del_pct;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      live_rules = 0;
      none = '0;
      for (int i = 0; i < RULE_SLOTS; i++)
         rule_mem[i] = '0;

      add_row(OP_CHECK, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1, ST_REJECT, 0);
      add_row(OP_DEL, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1, ST_NO_MATCH, 0);
      add_row(OP_ADD, 32'h5, 32'h5, 16'h1, 16'h0, 1'b1, 1'b0, 1'b1, ST_ADD_INVALID, 0);
      add_row(OP_ADD, ADDR_TOP, 32'h0, 16'h1, 16'h0, 1'b1, 1'b0, 1'b1, ST_ADD_INVALID, 0);
      add_row(OP_ADD, 32'h7, 32'h0, 16'd100, 16'd99, 1'b0, 1'b1, 1'b1, ST_ADD_INVALID, 0);
      add_row(OP_DEL, 32'h7, 32'h0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, ST_DEL_INVALID, 0);
      add_row(OP_DEL, 32'h1, 32'h0, 16'h0, 16'h0, 1'b1, 1'b0, 1'b1, ST_DEL_INVALID, 0);
      add_row(OP_CHECK, 32'h1, 32'h2, 16'h0, 16'h0, 1'b1, 1'b0, 1'b1, ST_ILLEGAL, 0);
      add_row(OP_CHECK, 32'h1, 32'h0, 16'h0, 16'h9, 1'b0, 1'b1, 1'b1, ST_ILLEGAL, 0);
      add_row(OP_UNKNOWN, ADDR_TOP, ADDR_TOP, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1,
              ST_ILLEGAL, 0);
      add_row(OP_ADD, ADDR_TOP, 32'h1234_5678, 16'hFFFF, 16'h0, 1'b0, 1'b0, 1'b1,
              ST_ADDED, 1);
      add_row(OP_ADD, 32'h0, ADDR_TOP, 16'h0, 16'hFFFF, 1'b1, 1'b1, 1'b1, ST_ADDED, 2);
      add_row(OP_ADD, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1, ST_ADDED, 3);
      add_row(OP_CHECK, ADDR_TOP, 32'h0, 16'hFFFF, 16'h0, 1'b0, 1'b0, 1'b1, ST_ACCEPT, 3);
      add_row(OP_CHECK, 32'hC0A8_0001, 32'h0, 16'd443, 16'h0, 1'b0, 1'b0, 1'b1,
              ST_ACCEPT, 3);
      add_row(OP_DEL, 32'h0, ADDR_TOP, 16'h0, 16'hFFFF, 1'b1, 1'b1, 1'b1, ST_DELETED, 2);
      add_row(OP_CHECK, 32'hC0A8_0001, 32'h0, 16'd443, 16'h0, 1'b0, 1'b0, 1'b1,
              ST_REJECT, 2);
      add_row(OP_ADD, 32'h0A00_0000, 32'h0A00_00FF, 16'd80, 16'd7, 1'b1, 1'b0, 1'b0,
              ST_ADDED, 0);
      add_row(OP_CHECK, 32'h0A00_00FF, 32'h0, 16'd80, 16'h0, 1'b0, 1'b0, 1'b0,
              ST_ACCEPT, 0);
      add_row(OP_CHECK, 32'h0A00_0100, 32'h0, 16'd80, 16'h0, 1'b0, 1'b0, 1'b0,
              ST_REJECT, 0);
      add_row(OP_ADD, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1, ST_ADDED, 4);
      add_row(OP_DEL, 32'h0, 32'hDEAD_BEEF, 16'h0, 16'h1234, 1'b0, 1'b0, 1'b1,
              ST_DELETED, 3);
      add_row(OP_DEL, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1, ST_DELETED, 2);
      add_row(OP_DEL, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1, ST_NO_MATCH, 2);
      add_row(OP_DEL, 32'h0A00_0000, 32'h0A00_00FE, 16'd80, 16'h0, 1'b1, 1'b0, 1'b0,
              ST_NO_MATCH, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         offer_item(directed_rows[r].it, directed_rows[r].known, directed_rows[r].v);
      wait_replies();

      // first phase is add-heavy and pushes the table toward full
      sent = 0;
      kind = 0;
      while (sent < RANDOM_ITEMS) begin
         case (kind)
            0: begin
               add_pct = 80;
               del_pct = 5;
            end
            1: begin
               add_pct = 35;
               del_pct = 30;
            end
            2: begin
               add_pct = 10;
               del_pct = 70;
            end
            default: begin
               add_pct = 15;
               del_pct = 15;
            end
         endcase
         phase_len = $urandom_range(60, 160);
         if (phase_len > RANDOM_ITEMS - sent)
            phase_len = RANDOM_ITEMS - sent;
         repeat (phase_len) begin
            offer_item(make_item(add_pct, del_pct), 1'b0, none);
            sent++;
         end
         wait_replies();
         kind = $urandom_range(0, 3);
      end

      repeat (4 * RULE_SLOTS) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int seg;
      int n;
      int kind;
      seg = 0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         seg++;
         n = $urandom_range(10, 250);
         kind = $urandom_range(0, 2);
         if (seg % 20 == 5) begin
            // long hold so the block backs up into its input
            rsp_tready <= 1'b0;
            repeat ($urandom_range(300, 500)) @(posedge clock);
         end else begin
            repeat (n) begin
               case (kind)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  default: rsp_tready <= ($urandom_range(0, 7) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[3:0];
         got.rules = rsp_tdata[4 +: COUNT_W];
         if (pending_verdicts.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, status %0d rules_in_use %0d",
                     $time, got.status, got.rules);
         end else begin
            want = pending_verdicts.pop_front();
            if (got.status !== want.status) begin
               errors++;
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, got.status);
            end
            if (got.rules !== want.rules) begin
               errors++;
               $display("%0t: rules_in_use mismatch, expected %0d, actual %0d",
                        $time, want.rules, got.rules);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/frrt_pkg.sv
rtl/core/frrt_ctrl.sv
rtl/core/frrt_dp.sv
rtl/core/firewall_range_rule_table_core.sv
dv/firewall_range_rule_table_core_tb.sv
